/* rtl/pzs_pkg.sv */
`timescale 1ns / 1ps
// Shared constants, datapath command codes and status struct for the peak z-score summary.
package pzs_pkg;

    localparam int SCORE_W     = 24;       // Q8.16 score width
    localparam int FRAC_W      = 16;       // fraction bits of Q8.16
    localparam int IDX_W       = 10;       // index offset register width
    localparam int PIDX_W      = 11;       // reported peak index width
    localparam int IDX_RESET   = 2;        // index offset after reset
    localparam int MAX_RUN_DEF = 256;      // default longest counted run
    localparam int Z_MAX       = 8388607;  // positive saturation of the z field

    // Datapath operations issued by the controller, one per cycle
    typedef enum logic [3:0] {
        OP_NONE,
        OP_CAPTURE,
        OP_ACCUM,
        OP_NQ_LOAD,
        OP_MUL_STEP,
        OP_SS_LOAD,
        OP_DIFF,
        OP_SQRT_STEP,
        OP_NUMER,
        OP_DIV_LOAD,
        OP_DIV_STEP,
        OP_FINISH
    } dp_op_t;

    // Datapath flags seen by the controller
    typedef struct packed {
        logic last;       // captured request closes the run
        logic empty;      // no present score in the run
        logic mul_zero;   // shift-add multiplier has no bits left
        logic cnt_zero;   // sqrt / divide step counter expired
        logic root_zero;  // integer square root is zero
    } dp_status_t;

endpackage

/* rtl/pzs_dp.sv */
`timescale 1ns / 1ps
// Datapath: run accumulators, shift-add multiplier, digit square root and restoring divider.
module pzs_dp #(
    parameter int MAX_RUN = pzs_pkg::MAX_RUN_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_wr_en,
    input  logic        [pzs_pkg::IDX_W-1:0]     cfg_wr_data,
    input  logic signed [pzs_pkg::SCORE_W-1:0]   s_score,
    input  logic                                 s_missing,
    input  logic                                 s_last,
    input  pzs_pkg::dp_op_t                      op,
    output pzs_pkg::dp_status_t                  status,
    output logic                                 m_found,
    output logic        [pzs_pkg::PIDX_W-1:0]    m_peak_index,
    output logic signed [pzs_pkg::SCORE_W-1:0]   m_peak_value,
    output logic signed [pzs_pkg::SCORE_W-1:0]   m_peak_z
);

    localparam int SW    = pzs_pkg::SCORE_W;
    localparam int N_W   = $clog2(MAX_RUN + 1);
    localparam int LG    = $clog2(MAX_RUN);
    localparam int BP_W  = (LG < 1) ? 1 : LG;
    localparam int SUM_W = SW + LG;
    localparam int SQ_W  = 2 * SW - 1 + LG;
    localparam int NQ_W  = N_W + SQ_W;
    localparam int SS_W  = 2 * SUM_W;
    localparam int D_W   = (NQ_W > SS_W) ? NQ_W : SS_W;
    localparam int R_W   = (D_W + 1) / 2;
    localparam int MP_W  = (SUM_W > N_W) ? SUM_W : N_W;
    localparam int NB_W  = N_W + 1 + SW;
    localparam int NUM_W = NB_W + 1;
    localparam int DV_W  = NUM_W + pzs_pkg::FRAC_W;
    localparam int CMAX  = (DV_W > R_W) ? DV_W : R_W;
    localparam int CNT_W = $clog2(CMAX + 1);

    // Configuration and captured request
    logic        [pzs_pkg::IDX_W-1:0] idx_off_reg;
    logic signed [SW-1:0]             score_reg;
    logic                             missing_reg, last_reg;

    // Run state
    logic signed [SUM_W-1:0] sum_reg, sum_next;
    logic        [SQ_W-1:0]  sq_reg, sq_next;
    logic        [N_W-1:0]   count_reg, count_next;
    logic signed [SW-1:0]    best_reg, best_next;
    logic        [BP_W-1:0]  best_pos_reg, best_pos_next;
    logic        [N_W-1:0]   item_pos_reg, item_pos_next;

    // End-of-run work registers
    logic        [D_W-1:0]   mcand_reg, mcand_next;
    logic        [MP_W-1:0]  mplier_reg, mplier_next;
    logic        [D_W-1:0]   acc_reg, acc_next;
    logic        [D_W-1:0]   nq_reg, nq_next;
    logic        [2*R_W-1:0] rad_reg, rad_next;
    logic        [R_W+1:0]   srem_reg, srem_next;
    logic        [R_W-1:0]   root_reg, root_next;
    logic signed [NB_W-1:0]  nb_reg, nb_next;
    logic        [DV_W-1:0]  quo_reg, quo_next;
    logic        [R_W-1:0]   drem_reg, drem_next;
    logic        [CNT_W-1:0] cnt_reg, cnt_next;

    // Result registers
    logic                             found_reg, found_next;
    logic        [pzs_pkg::PIDX_W-1:0] pidx_reg, pidx_next;
    logic signed [SW-1:0]             pval_reg, pval_next;
    logic signed [SW-1:0]             pz_reg, pz_next;

    // Helper terms
    logic signed [2*SW-1:0]  sq_prod;
    logic                    in_range, take_new;
    logic        [SUM_W-1:0] abs_sum;
    logic        [D_W-1:0]   d_val;
    logic        [R_W+3:0]   s_part, s_trial, s_diff;
    logic                    s_ge;
    logic signed [NUM_W-1:0] num;
    logic        [NUM_W-2:0] unum;
    logic        [DV_W-1:0]  dividend;
    logic        [R_W:0]     d_part, d_sub;
    logic                    d_ge;
    logic signed [SW-1:0]    z_sat;

    assign sq_prod  = score_reg * score_reg;
    assign in_range = item_pos_reg < N_W'(MAX_RUN);
    assign take_new = (count_reg == '0) || (score_reg > best_reg);
    assign abs_sum  = sum_reg[SUM_W-1] ? $unsigned(-sum_reg) : $unsigned(sum_reg);

    // Clamp n*Q - S*S at zero
    assign d_val = (nq_reg > acc_reg) ? (nq_reg - acc_reg) : '0;

    // One root bit per step
    assign s_part  = {srem_reg, rad_reg[2*R_W-1 -: 2]};
    assign s_trial = {2'b00, root_reg, 2'b01};
    assign s_ge    = s_part >= s_trial;
    assign s_diff  = s_part - s_trial;

    // Numerator n*max - S, rounded dividend
    assign num      = NUM_W'(nb_reg) - NUM_W'(sum_reg);
    assign unum     = num[NUM_W-1] ? '0 : num[NUM_W-2:0];
    assign dividend = DV_W'({unum, {pzs_pkg::FRAC_W{1'b0}}}) + DV_W'(root_reg[R_W-1:1]);

    // One quotient bit per step
    assign d_part = {drem_reg, quo_reg[DV_W-1]};
    assign d_ge   = d_part >= {1'b0, root_reg};
    assign d_sub  = d_part - {1'b0, root_reg};

    assign z_sat = (quo_reg > DV_W'(pzs_pkg::Z_MAX)) ? SW'(pzs_pkg::Z_MAX)
                                                     : quo_reg[SW-1:0];

    // Next-state logic per operation
    always_comb begin
        sum_next      = sum_reg;
        sq_next       = sq_reg;
        count_next    = count_reg;
        best_next     = best_reg;
        best_pos_next = best_pos_reg;
        item_pos_next = item_pos_reg;
        mcand_next    = mcand_reg;
        mplier_next   = mplier_reg;
        acc_next      = acc_reg;
        nq_next       = nq_reg;
        rad_next      = rad_reg;
        srem_next     = srem_reg;
        root_next     = root_reg;
        nb_next       = nb_reg;
        quo_next      = quo_reg;
        drem_next     = drem_reg;
        cnt_next      = cnt_reg;
        found_next    = found_reg;
        pidx_next     = pidx_reg;
        pval_next     = pval_reg;
        pz_next       = pz_reg;
        unique case (op)
            pzs_pkg::OP_ACCUM: begin
                if (in_range) begin
                    if (!missing_reg) begin
                        sum_next   = sum_reg + SUM_W'(score_reg);
                        sq_next    = sq_reg + SQ_W'($unsigned(sq_prod));
                        count_next = count_reg + N_W'(1);
                        if (take_new) begin
                            best_next     = score_reg;
                            best_pos_next = BP_W'(item_pos_reg);
                        end
                    end
                    item_pos_next = item_pos_reg + N_W'(1);
                end
            end
            pzs_pkg::OP_NQ_LOAD: begin
                mcand_next  = D_W'(sq_reg);
                mplier_next = MP_W'(count_reg);
                acc_next    = '0;
            end
            pzs_pkg::OP_MUL_STEP: begin
                if (mplier_reg[0]) begin
                    acc_next = acc_reg + mcand_reg;
                end
                mcand_next  = {mcand_reg[D_W-2:0], 1'b0};
                mplier_next = {1'b0, mplier_reg[MP_W-1:1]};
            end
            pzs_pkg::OP_SS_LOAD: begin
                nq_next     = acc_reg;
                mcand_next  = D_W'(abs_sum);
                mplier_next = MP_W'(abs_sum);
                acc_next    = '0;
            end
            pzs_pkg::OP_DIFF: begin
                rad_next  = (2*R_W)'(d_val);
                srem_next = '0;
                root_next = '0;
                cnt_next  = CNT_W'(R_W);
            end
            pzs_pkg::OP_SQRT_STEP: begin
                srem_next = s_ge ? s_diff[R_W+1:0] : s_part[R_W+1:0];
                root_next = {root_reg[R_W-2:0], s_ge};
                rad_next  = {rad_reg[2*R_W-3:0], 2'b00};
                cnt_next  = cnt_reg - CNT_W'(1);
            end
            pzs_pkg::OP_NUMER: begin
                nb_next = $signed({1'b0, count_reg}) * best_reg;
            end
            pzs_pkg::OP_DIV_LOAD: begin
                quo_next  = dividend;
                drem_next = '0;
                cnt_next  = CNT_W'(DV_W);
            end
            pzs_pkg::OP_DIV_STEP: begin
                drem_next = d_ge ? d_sub[R_W-1:0] : d_part[R_W-1:0];
                quo_next  = {quo_reg[DV_W-2:0], d_ge};
                cnt_next  = cnt_reg - CNT_W'(1);
            end
            pzs_pkg::OP_FINISH: begin
                if (count_reg == '0) begin
                    found_next = 1'b0;
                    pidx_next  = '0;
                    pval_next  = '0;
                    pz_next    = '0;
                end else begin
                    found_next = 1'b1;
                    pidx_next  = pzs_pkg::PIDX_W'(idx_off_reg)
                               + pzs_pkg::PIDX_W'(best_pos_reg);
                    pval_next  = best_reg;
                    pz_next    = (root_reg == '0) ? best_reg : z_sat;
                end
                // clear the run
                sum_next      = '0;
                sq_next       = '0;
                count_next    = '0;
                best_next     = '0;
                best_pos_next = '0;
                item_pos_next = '0;
            end
            default: begin
            end
        endcase
    end

    // Configuration register and run state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_off_reg  <= pzs_pkg::IDX_W'(pzs_pkg::IDX_RESET);
            sum_reg      <= '0;
            sq_reg       <= '0;
            count_reg    <= '0;
            best_reg     <= '0;
            best_pos_reg <= '0;
            item_pos_reg <= '0;
        end else begin
            if (cfg_wr_en) begin
                idx_off_reg <= cfg_wr_data;
            end
            sum_reg      <= sum_next;
            sq_reg       <= sq_next;
            count_reg    <= count_next;
            best_reg     <= best_next;
            best_pos_reg <= best_pos_next;
            item_pos_reg <= item_pos_next;
        end
    end

    // Captured request, work and result registers
    always_ff @(posedge aclk) begin
        if (op == pzs_pkg::OP_CAPTURE) begin
            score_reg   <= s_score;
            missing_reg <= s_missing;
            last_reg    <= s_last;
        end
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
        acc_reg    <= acc_next;
        nq_reg     <= nq_next;
        rad_reg    <= rad_next;
        srem_reg   <= srem_next;
        root_reg   <= root_next;
        nb_reg     <= nb_next;
        quo_reg    <= quo_next;
        drem_reg   <= drem_next;
        cnt_reg    <= cnt_next;
        found_reg  <= found_next;
        pidx_reg   <= pidx_next;
        pval_reg   <= pval_next;
        pz_reg     <= pz_next;
    end

    assign status.last      = last_reg;
    assign status.empty     = (count_reg == '0);
    assign status.mul_zero  = (mplier_reg == '0);
    assign status.cnt_zero  = (cnt_reg == '0);
    assign status.root_zero = (root_reg == '0);

    assign m_found      = found_reg;
    assign m_peak_index = pidx_reg;
    assign m_peak_value = pval_reg;
    assign m_peak_z     = pz_reg;

    // Present count never runs ahead of the position counter
    a_count_le_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= item_pos_reg)
        else $error("present count exceeds run position");

    // Position counter stops at the run limit
    a_pos_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        item_pos_reg <= N_W'(MAX_RUN))
        else $error("run position beyond limit");

    // Divider remainder stays below the divisor
    a_div_rem: assert property (@(posedge aclk) disable iff (!aresetn)
        (op == pzs_pkg::OP_DIV_STEP) |-> (drem_reg < root_reg))
        else $error("divider remainder out of range");

endmodule

/* rtl/pzs_ctrl.sv */
`timescale 1ns / 1ps
// Controller: sequences request capture, accumulation and the end-of-run arithmetic.
module pzs_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    output logic                m_valid,
    input  logic                m_ready,
    input  pzs_pkg::dp_status_t status,
    output pzs_pkg::dp_op_t     op
);

    typedef enum logic [8:0] {
        ST_IDLE   = 9'b000000001,
        ST_ACC    = 9'b000000010,
        ST_START  = 9'b000000100,
        ST_MUL_NQ = 9'b000001000,
        ST_MUL_SS = 9'b000010000,
        ST_SQRT   = 9'b000100000,
        ST_SUBN   = 9'b001000000,
        ST_DIV    = 9'b010000000,
        ST_DONE   = 9'b100000000
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;

    // State transitions and datapath operation
    always_comb begin
        state_next = state_reg;
        op         = pzs_pkg::OP_NONE;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    op         = pzs_pkg::OP_CAPTURE;
                    state_next = ST_ACC;
                end
            end
            ST_ACC: begin
                op         = pzs_pkg::OP_ACCUM;
                state_next = status.last ? ST_START : ST_IDLE;
            end
            ST_START: begin
                if (status.empty) begin
                    state_next = ST_DONE;
                end else begin
                    op         = pzs_pkg::OP_NQ_LOAD;
                    state_next = ST_MUL_NQ;
                end
            end
            ST_MUL_NQ: begin
                if (status.mul_zero) begin
                    op         = pzs_pkg::OP_SS_LOAD;
                    state_next = ST_MUL_SS;
                end else begin
                    op = pzs_pkg::OP_MUL_STEP;
                end
            end
            ST_MUL_SS: begin
                if (status.mul_zero) begin
                    op         = pzs_pkg::OP_DIFF;
                    state_next = ST_SQRT;
                end else begin
                    op = pzs_pkg::OP_MUL_STEP;
                end
            end
            ST_SQRT: begin
                if (status.cnt_zero) begin
                    op         = pzs_pkg::OP_NUMER;
                    state_next = ST_SUBN;
                end else begin
                    op = pzs_pkg::OP_SQRT_STEP;
                end
            end
            ST_SUBN: begin
                if (status.root_zero) begin
                    state_next = ST_DONE;
                end else begin
                    op         = pzs_pkg::OP_DIV_LOAD;
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                if (status.cnt_zero) begin
                    state_next = ST_DONE;
                end else begin
                    op = pzs_pkg::OP_DIV_STEP;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    op         = pzs_pkg::OP_FINISH;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output register valid
    always_comb begin
        if (op == pzs_pkg::OP_FINISH) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;

    // An accepted request is accumulated in the next cycle
    a_accept_acc: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == ST_ACC))
        else $error("accepted request not accumulated");

    // A new result never overwrites one still waiting
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (op == pzs_pkg::OP_FINISH) |-> (!m_valid_reg || m_ready))
        else $error("result overwritten before taken");

    // Division only runs against a nonzero root
    a_div_root: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV) |-> !status.root_zero)
        else $error("divide by zero root");

endmodule

/* rtl/peak_zscore_summary.sv */
`timescale 1ns / 1ps
// Top level: peak and z-score summary of a run of Q8.16 scores.
//
//  channel  direction  handshake              payload
//  config   in         cfg_wr_en              cfg_wr_data (index offset)
//  s_       in         s_valid / s_ready      s_score, s_missing, s_last
//  m_       out        m_valid / m_ready      m_found, m_peak_index, m_peak_value, m_peak_z
//
// Each request passes through capture, then accumulate (one 24x24 square per request).
// The request closing a run adds the end-of-run sequence, set by the shift-add multiplier
// and the one-bit-per-cycle square root and divider; the sequence is shorter for a smaller
// sum, a zero root or an empty run.
// Reset is synchronous, active low; it clears the run state and sets the index offset to 2.
// The result waits in an output register; a finished run stalls only if one is still held.
module peak_zscore_summary #(
    parameter int MAX_RUN = pzs_pkg::MAX_RUN_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_wr_en,
    input  logic        [pzs_pkg::IDX_W-1:0]     cfg_wr_data,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic signed [pzs_pkg::SCORE_W-1:0]   s_score,
    input  logic                                 s_missing,
    input  logic                                 s_last,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic                                 m_found,
    output logic        [pzs_pkg::PIDX_W-1:0]    m_peak_index,
    output logic signed [pzs_pkg::SCORE_W-1:0]   m_peak_value,
    output logic signed [pzs_pkg::SCORE_W-1:0]   m_peak_z
);

    pzs_pkg::dp_op_t     op;
    pzs_pkg::dp_status_t status;

    // Sequencer
    pzs_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .op      (op)
    );

    // Arithmetic and result registers
    pzs_dp #(
        .MAX_RUN (MAX_RUN)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .s_score      (s_score),
        .s_missing    (s_missing),
        .s_last       (s_last),
        .op           (op),
        .status       (status),
        .m_found      (m_found),
        .m_peak_index (m_peak_index),
        .m_peak_value (m_peak_value),
        .m_peak_z     (m_peak_z)
    );

endmodule
